/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file hw/rtl/glphs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/glphs_pkg.sv */
// Shared types, constants and helper functions of the grid pattern hash search.
`default_nettype none

package glphs_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLS    = 32;
    localparam int GRID_CELLS  = MAX_ROWS * MAX_COLS;
    localparam int CELL_AW     = $clog2(GRID_CELLS);
    localparam int LPOS_W      = CELL_AW + 1;
    localparam int LEN_SAT     = ((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1;
    localparam int DIM_W       = 6;
    localparam int LEN_W       = 6;
    localparam int SYM_W       = 8;
    localparam int HASH_W      = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIM_W-1:0] MAX_ROWS_D = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] MAX_COLS_D = DIM_W'(MAX_COLS);
    localparam logic [LEN_W-1:0] LEN_SAT_L  = LEN_W'(LEN_SAT);

    typedef logic [HASH_W-1:0] hash_t;

    typedef struct packed {
        hash_t             hash;
        hash_t             power;
        logic [LEN_W-1:0]  len;
    } job_t;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] addr;
        logic [SYM_W-1:0]   data;
    } grid_wr_t;

    // Multiplication by the hash base 131 as shifts and adds.
    function automatic hash_t mul_base(input hash_t x);
        return (x << 7) + (x << 1) + x;
    endfunction

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                                 input logic [DIM_W-1:0] maxv);
        if (r == '0) begin
            return DIM_W'(1);
        end
        if (r > maxv) begin
            return maxv;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/glphs_queue.sv */
// Short job queue between the front and the back of the search.
`default_nettype none

module glphs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  glphs_pkg::job_t push_job,
    input  logic           pop,
    output glphs_pkg::job_t head,
    output logic           empty,
    output logic           full
);
    import glphs_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/glphs_front.sv */
// Front part: grid loading and pattern hash accumulation.
`default_nettype none

module glphs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          mode,
    input  logic [glphs_pkg::SYM_W-1:0]   symbol,
    input  logic                          pattern_end,
    input  logic [glphs_pkg::DIM_W-1:0]   rows_eff,
    input  logic [glphs_pkg::DIM_W-1:0]   cols_eff,
    output glphs_pkg::grid_wr_t           grid_wr,
    output logic                          push,
    output glphs_pkg::job_t               push_job
);
    import glphs_pkg::*;

    logic [LPOS_W-1:0] load_pos_reg;
    hash_t             hash_reg;
    hash_t             power_reg;
    logic [LEN_W-1:0]  count_reg;

    logic [LPOS_W-1:0] cells_in_use;
    logic [LPOS_W-1:0] wr_pos;
    hash_t             hash_next;
    hash_t             power_next;
    logic [LEN_W-1:0]  count_next;
    logic              grid_item;
    logic              pat_item;

    assign grid_item    = accept && !mode;
    assign pat_item     = accept && mode;
    assign cells_in_use = LPOS_W'(LPOS_W'(rows_eff) * LPOS_W'(cols_eff));
    assign wr_pos       = (load_pos_reg >= cells_in_use) ? '0 : load_pos_reg;

    assign hash_next = mul_base(hash_reg) + hash_t'(symbol);

    always_comb begin
        if (count_reg < LEN_SAT_L) begin
            count_next = count_reg + 1'b1;
            power_next = mul_base(power_reg);
        end
        else begin
            count_next = count_reg;
            power_next = power_reg;
        end
    end

    assign grid_wr.en   = grid_item;
    assign grid_wr.addr = wr_pos[CELL_AW-1:0];
    assign grid_wr.data = symbol;

    assign push           = pat_item && pattern_end;
    assign push_job.hash  = hash_next;
    assign push_job.power = power_next;
    assign push_job.len   = count_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            load_pos_reg <= '0;
            hash_reg     <= '0;
            power_reg    <= hash_t'(1);
            count_reg    <= '0;
        end
        else begin
            if (grid_item) begin
                load_pos_reg <= wr_pos + 1'b1;
            end
            if (pat_item) begin
                if (pattern_end) begin
                    hash_reg  <= '0;
                    power_reg <= hash_t'(1);
                    count_reg <= '0;
                end
                else begin
                    hash_reg  <= hash_next;
                    power_reg <= power_next;
                    count_reg <= count_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/glphs_back.sv */
// Back part: grid memory and the rolling hash scan over rows and columns.
`default_nettype none

module glphs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  glphs_pkg::grid_wr_t           grid_wr,
    input  glphs_pkg::job_t               head,
    input  logic                          q_empty,
    input  logic [glphs_pkg::DIM_W-1:0]   rows_eff,
    input  logic [glphs_pkg::DIM_W-1:0]   cols_eff,
    output logic                          pop,
    output logic                          back_busy,
    output logic                          done,
    output logic                          found,
    output logic [glphs_pkg::LEN_W-1:0]   pattern_length
);
    import glphs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ROW,
        S_COL,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [DIM_W-1:0]   a_reg;
    logic [DIM_W-1:0]   b_reg;
    logic [CELL_AW-1:0] idx_reg;
    logic [LPOS_W-1:0]  lencols_reg;
    logic               drain_reg;
    logic               found_reg;

    logic [SYM_W-1:0]   mem [GRID_CELLS];
    logic [SYM_W-1:0]   rd_new_reg;
    logic [SYM_W-1:0]   rd_old_reg;

    logic               s1_valid_reg;
    logic               s1_first_reg;
    logic               s1_sub_reg;
    logic               s1_chk_reg;
    logic               s2_valid_reg;
    logic               s2_chk_reg;
    hash_t              h_reg;

    logic               issue;
    logic               in_row;
    logic [DIM_W-1:0]   span;
    logic [DIM_W-1:0]   lines;
    logic               line_end;
    logic               last_line;
    logic [CELL_AW-1:0] old_idx;
    logic               first;
    logic               sub;
    logic               chk;
    hash_t              h_calc;
    hash_t              h_prev;
    hash_t              h_drop;
    logic               hit;

    assign in_row    = (state_reg == S_ROW);
    assign issue     = (state_reg == S_ROW) || (state_reg == S_COL);
    assign span      = in_row ? cols_eff : rows_eff;
    assign lines     = in_row ? rows_eff : cols_eff;
    assign line_end  = (b_reg == span - 1'b1);
    assign last_line = (a_reg == lines - 1'b1);
    assign old_idx   = in_row ? CELL_AW'(LPOS_W'(idx_reg) - LPOS_W'(head.len))
                              : CELL_AW'(LPOS_W'(idx_reg) - lencols_reg);
    assign first     = (b_reg == '0);
    assign sub       = (b_reg >= head.len);
    assign chk       = ((DIM_W + 1)'(b_reg) + 1'b1 >= (DIM_W + 1)'(head.len));

    always_ff @(posedge clk) begin
        if (grid_wr.en) begin
            mem[grid_wr.addr] <= grid_wr.data;
        end
        rd_new_reg <= mem[idx_reg];
        rd_old_reg <= mem[old_idx];
    end

    assign h_prev = s1_first_reg ? '0 : h_reg;
    assign h_drop = s1_sub_reg ? hash_t'(head.power * rd_old_reg) : '0;
    assign h_calc = mul_base(h_prev) + hash_t'(rd_new_reg) - h_drop;
    assign hit    = s2_valid_reg && s2_chk_reg && (h_reg == head.hash);

    always_ff @(posedge clk) begin
        if (s1_valid_reg) begin
            h_reg <= h_calc;
        end
    end

    assign pop            = (state_reg == S_DONE);
    assign done           = (state_reg == S_DONE);
    assign back_busy      = (state_reg != S_IDLE);
    assign found          = found_reg;
    assign pattern_length = head.len;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            a_reg        <= '0;
            b_reg        <= '0;
            idx_reg      <= '0;
            lencols_reg  <= '0;
            drain_reg    <= 1'b0;
            found_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_sub_reg   <= 1'b0;
            s1_chk_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_chk_reg   <= 1'b0;
        end
        else begin
            s1_valid_reg <= issue && !hit;
            s1_first_reg <= first;
            s1_sub_reg   <= sub;
            s1_chk_reg   <= chk;
            s2_valid_reg <= s1_valid_reg && !hit;
            s2_chk_reg   <= s1_chk_reg;
            unique case (state_reg)
                S_IDLE: begin
                    found_reg <= 1'b0;
                    if (!q_empty) begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    lencols_reg <= LPOS_W'(LPOS_W'(head.len) * LPOS_W'(cols_eff));
                    a_reg       <= '0;
                    b_reg       <= '0;
                    idx_reg     <= '0;
                    drain_reg   <= 1'b0;
                    if (head.len <= cols_eff) begin
                        state_reg <= S_ROW;
                    end
                    else if (head.len <= rows_eff) begin
                        state_reg <= S_COL;
                    end
                    else begin
                        state_reg <= S_DONE;
                    end
                end
                S_ROW, S_COL: begin
                    if (hit) begin
                        found_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (line_end) begin
                        b_reg <= '0;
                        if (last_line) begin
                            a_reg   <= '0;
                            idx_reg <= '0;
                            if (in_row && (head.len <= rows_eff)) begin
                                state_reg <= S_COL;
                            end
                            else begin
                                state_reg <= S_DRAIN;
                            end
                        end
                        else begin
                            a_reg   <= a_reg + 1'b1;
                            idx_reg <= in_row ? idx_reg + 1'b1
                                              : CELL_AW'(a_reg + 1'b1);
                        end
                    end
                    else begin
                        b_reg   <= b_reg + 1'b1;
                        idx_reg <= in_row ? idx_reg + 1'b1
                                          : idx_reg + CELL_AW'(cols_eff);
                    end
                end
                S_DRAIN: begin
                    drain_reg <= 1'b1;
                    if (hit) begin
                        found_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (drain_reg) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/grid_line_pattern_hash_search.sv */
// Top level of the grid line pattern hash search.
//
//  Channel   Signals                              Direction
//  request   start, busy, mode, symbol, pattern_end  in (busy out)
//  result    done, found, pattern_length             out
//  config    psel, penable, pwrite, paddr, pwdata,   in/out
//            prdata, pready
//
// A grid byte is held off while a search is queued or running.
// A pattern byte is held off only while the queue is full.
// The queue holds two finished patterns, the one being searched included.
// A search with both scans reads one grid cell per cycle, first along the rows and
// then along the columns, and stops early on the first hit.
// Reset clears all control state; the grid memory is not cleared.
// Each result is shown for one cycle on done and cannot be stalled.
`default_nettype none

module grid_line_pattern_hash_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [glphs_pkg::SYM_W-1:0]   symbol,
    input  logic                          pattern_end,
    output logic                          done,
    output logic                          found,
    output logic [glphs_pkg::LEN_W-1:0]   pattern_length,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import glphs_pkg::*;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    logic [DIM_W-1:0] grid_rows_reg;
    logic [DIM_W-1:0] grid_cols_reg;
    logic [DIM_W-1:0] rows_eff;
    logic [DIM_W-1:0] cols_eff;
    logic             accept;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    logic             back_busy;
    job_t             push_job;
    job_t             head;
    grid_wr_t         grid_wr;

    assign pready   = 1'b1;
    assign rows_eff = eff_dim(grid_rows_reg, MAX_ROWS_D);
    assign cols_eff = eff_dim(grid_cols_reg, MAX_COLS_D);
    assign busy     = q_full || (!mode && (!q_empty || back_busy));
    assign accept   = start && !busy;

    always_comb begin
        unique case (paddr[2])
            REG_ROWS: prdata = {{(32 - DIM_W){1'b0}}, grid_rows_reg};
            REG_COLS: prdata = {{(32 - DIM_W){1'b0}}, grid_cols_reg};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            grid_rows_reg <= DIM_W'(32);
            grid_cols_reg <= DIM_W'(32);
        end
        else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_ROWS) begin
                grid_rows_reg <= pwdata[DIM_W-1:0];
            end
            else begin
                grid_cols_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    glphs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .symbol      (symbol),
        .pattern_end (pattern_end),
        .rows_eff    (rows_eff),
        .cols_eff    (cols_eff),
        .grid_wr     (grid_wr),
        .push        (push),
        .push_job    (push_job)
    );

    glphs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    glphs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .grid_wr        (grid_wr),
        .head           (head),
        .q_empty        (q_empty),
        .rows_eff       (rows_eff),
        .cols_eff       (cols_eff),
        .pop            (pop),
        .back_busy      (back_busy),
        .done           (done),
        .found          (found),
        .pattern_length (pattern_length)
    );

endmodule

`default_nettype wire

/* hw/rtl/glphs_checker.sv */
// Port-level assertions for the grid line pattern hash search, with their bind.
`default_nettype none

`include "assert_macros.svh"

module glphs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        mode,
    input logic                        done,
    input logic                        found,
    input logic [glphs_pkg::LEN_W-1:0] pattern_length,
    input logic                        pready
);
    import glphs_pkg::*;

    `CHK_NEXT(a_done_single, clk, rst_n, done, !done)
    `CHK_SAME(a_len_range, clk, rst_n, done,
              (pattern_length != '0) && (pattern_length <= LEN_SAT_L))
    `CHK_SAME(a_long_miss, clk, rst_n, done && (pattern_length == LEN_SAT_L), !found)
    `CHK_SAME(a_grid_after_req, clk, rst_n, start && !busy && !mode, !done)
    `CHK_SAME(a_ready_high, clk, rst_n, 1'b1, pready)

endmodule

bind grid_line_pattern_hash_search glphs_checker u_glphs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .done           (done),
    .found          (found),
    .pattern_length (pattern_length),
    .pready         (pready)
);

`default_nettype wire

/* tb/glphs_checker.sv */
// Checker for the grid line pattern search: snoops requests, predicts results and compares them.
module glphs_scoreboard #(
    parameter logic [2:0] ADDR_ROWS = 3'd0,
    parameter logic [2:0] ADDR_COLS = 3'd4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          mode,
    input  logic [glphs_pkg::SYM_W-1:0]   symbol,
    input  logic                          pattern_end,
    input  logic                          done,
    input  logic                          found,
    input  logic [glphs_pkg::LEN_W-1:0]   pattern_length,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count,
    output int                            hit_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                        hit;
        logic [glphs_pkg::LEN_W-1:0] len;
    } search_answer_t;

    localparam logic [63:0] BASE = 64'd131;

    search_answer_t answers_due[$];
    logic [7:0]  grid_img [0:glphs_pkg::GRID_CELLS-1];
    int          load_pos;
    logic [63:0] pat_hash;
    logic [63:0] pat_power;
    int          pat_len;
    logic [5:0]  rows_reg;
    logic [5:0]  cols_reg;

    function automatic int clamp_dim(logic [5:0] r, int maxv);
        if (r == 6'd0)
            return 1;
        return (int'(r) > maxv) ? maxv : int'(r);
    endfunction

    function automatic logic [63:0] cell_at(int r, int c, int cols);
        return {56'd0, grid_img[r * cols + c]};
    endfunction

    function automatic bit lines_match(int lines, int span, bit by_row, int cols, int len);
        logic [63:0] h;
        logic [63:0] old;
        if (len > span)
            return 0;
        for (int a = 0; a < lines; a++)
        begin
            h = '0;
            for (int b = 0; b < span; b++)
            begin
                h = h * BASE + (by_row ? cell_at(a, b, cols) : cell_at(b, a, cols));
                if (b >= len)
                begin
                    old = by_row ? cell_at(a, b - len, cols) : cell_at(b - len, a, cols);
                    h = h - old * pat_power;
                end
                if (b + 1 >= len && h == pat_hash)
                    return 1;
            end
        end
        return 0;
    endfunction

    assign pending = answers_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        search_answer_t ans;
        int rows;
        int cols;
        if (!rst_n)
        begin
            answers_due.delete();
            load_pos = 0;
            pat_hash = '0;
            pat_power = 64'd1;
            pat_len = 0;
            rows_reg = 6'd32;
            cols_reg = 6'd32;
            fail_count = 0;
            result_count = 0;
            hit_count = 0;
            foreach (grid_img[i])
                grid_img[i] = 8'd0;
        end
        else
        begin
            if (done)
            begin
                result_count++;
                if (found)
                    hit_count++;
                if (answers_due.size() == 0)
                begin
                    $error("result with nothing expected: found=%0d pattern_length=%0d",
                           found, pattern_length);
                    fail_count++;
                end
                else
                begin
                    ans = answers_due.pop_front();
                    if (found !== ans.hit)
                    begin
                        $error("found: expected %0d, actual %0d", ans.hit, found);
                        fail_count++;
                    end
                    if (pattern_length !== ans.len)
                    begin
                        $error("pattern_length: expected %0d, actual %0d",
                               ans.len, pattern_length);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_ROWS)
                    rows_reg = pwdata[5:0];
                else if (paddr == ADDR_COLS)
                    cols_reg = pwdata[5:0];
            end
            if (start && !busy)
            begin
                rows = clamp_dim(rows_reg, glphs_pkg::MAX_ROWS);
                cols = clamp_dim(cols_reg, glphs_pkg::MAX_COLS);
                if (!mode)
                begin
                    if (load_pos >= rows * cols)
                        load_pos = 0;
                    grid_img[load_pos] = symbol;
                    load_pos++;
                end
                else
                begin
                    pat_hash = pat_hash * BASE + {56'd0, symbol};
                    if (pat_len < glphs_pkg::LEN_SAT)
                    begin
                        pat_len++;
                        pat_power = pat_power * BASE;
                    end
                    if (pattern_end)
                    begin
                        ans.hit = 1'b0;
                        if (pat_len <= rows || pat_len <= cols)
                            ans.hit = lines_match(rows, cols, 1, cols, pat_len)
                                   || lines_match(cols, rows, 0, cols, pat_len);
                        ans.len = pat_len[5:0];
                        answers_due.insert(answers_due.size(), ans);
                        pat_hash = '0;
                        pat_power = 64'd1;
                        pat_len = 0;
                    end
                end
            end
        end
    end
endmodule

/* tb/tb.sv */
// Testbench top: drives grid loads, query patterns and register writes, and gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;
    localparam logic       MODE_GRID = 1'b0;
    localparam logic       MODE_PATTERN = 1'b1;
    localparam int         TARGET_ITEMS = 1550;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [7:0]  symbol;
    logic        pattern_end;
    logic        done;
    logic        found;
    logic [5:0]  pattern_length;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          result_count;
    int          hit_count;

    logic [7:0]  grid_copy [0:1023];
    int          copy_pos;
    int          eff_rows;
    int          eff_cols;
    int          sent;
    int          idle_pct;
    int          settings_seen;

    grid_line_pattern_hash_search uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .symbol(symbol), .pattern_end(pattern_end), .done(done), .found(found),
        .pattern_length(pattern_length), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    glphs_scoreboard #(.ADDR_ROWS(ADDR_ROWS), .ADDR_COLS(ADDR_COLS)) u_scoreboard (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .symbol(symbol), .pattern_end(pattern_end), .done(done), .found(found),
        .pattern_length(pattern_length), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending), .result_count(result_count),
        .hit_count(hit_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #300ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_request(logic m, logic [7:0] s, logic e);
        idle_pct = (sent < TARGET_ITEMS / 3) ? 29 : ((sent < 2 * TARGET_ITEMS / 3) ? 45 : 0);
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        start = 1'b1;
        mode = m;
        symbol = s;
        pattern_end = e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start = 1'b0;
        sent++;
        if (m == MODE_GRID)
        begin
            if (copy_pos >= eff_rows * eff_cols)
                copy_pos = 0;
            grid_copy[copy_pos] = s;
            copy_pos++;
        end
    endtask

    task automatic wait_idle();
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    function automatic int clamp_dim(int r);
        if (r == 0)
            return 1;
        return (r > 32) ? 32 : r;
    endfunction

    function automatic logic [7:0] grid_symbol();
        return ($urandom_range(99) < 70) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    endfunction

    // Settles the block, sets the shape and fills every cell in use.
    task automatic new_shape(int r, int c, int extra);
        wait_idle();
        write_reg(ADDR_ROWS, 32'(r));
        write_reg(ADDR_COLS, 32'(c));
        eff_rows = clamp_dim(r & 63);
        eff_cols = clamp_dim(c & 63);
        settings_seen++;
        repeat (eff_rows * eff_cols + extra)
            send_request(MODE_GRID, grid_symbol(), 1'($urandom_range(1)));
    endtask

    task automatic send_pattern(logic [7:0] chars[$]);
        foreach (chars[i])
            send_request(MODE_PATTERN, chars[i], i == chars.size() - 1);
    endtask

    // A window taken from the loaded grid, so most of these should hit.
    task automatic send_window();
        logic [7:0] chars[$];
        bit by_row;
        int span;
        int lines;
        int len;
        int a;
        int b0;
        by_row = $urandom_range(1);
        span = by_row ? eff_cols : eff_rows;
        lines = by_row ? eff_rows : eff_cols;
        len = $urandom_range(span, 1);
        a = $urandom_range(lines - 1);
        b0 = $urandom_range(span - len);
        for (int k = 0; k < len; k++)
            chars.insert(chars.size(), by_row ? grid_copy[a * eff_cols + b0 + k]
                                              : grid_copy[(b0 + k) * eff_cols + a]);
        if ($urandom_range(9) == 0)
            chars[$urandom_range(len - 1)] = 8'($urandom_range(255));
        send_pattern(chars);
    endtask

    task automatic send_random_pattern(int len);
        logic [7:0] chars[$];
        repeat (len)
            chars.insert(chars.size(), grid_symbol());
        send_pattern(chars);
    endtask

    task automatic random_traffic(int count);
        int pick;
        int longest;
        for (int n = 0; n < count; n++)
        begin
            longest = (eff_rows > eff_cols) ? eff_rows : eff_cols;
            pick = $urandom_range(99);
            if (pick < 60)
                send_window();
            else if (pick < 80)
                send_random_pattern($urandom_range(longest + 2, 1));
            else if (pick < 88)
                send_random_pattern($urandom_range(40, longest + 1));
            else if (pick < 95)
                send_request(MODE_GRID, grid_symbol(), 1'b1);
            else
            begin
                send_request(MODE_PATTERN, grid_symbol(), 1'b0);
                send_request(MODE_GRID, grid_symbol(), 1'($urandom_range(1)));
                send_request(MODE_PATTERN, grid_symbol(), 1'b1);
            end
        end
    endtask

    initial
    begin
        logic [7:0] chars[$];
        int r;
        int c;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_GRID;
        symbol = 8'd0;
        pattern_end = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_ROWS;
        pwdata = 32'd0;
        sent = 0;
        idle_pct = 0;
        copy_pos = 0;
        settings_seen = 0;
        eff_rows = 32;
        eff_cols = 32;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: a small grid with extreme bytes, then the corner cases of patterns.
        wait_idle();
        write_reg(ADDR_ROWS, 32'd3);
        write_reg(ADDR_COLS, 32'd4);
        eff_rows = 3;
        eff_cols = 4;
        settings_seen++;
        for (int i = 0; i < 12; i++)
            send_request(MODE_GRID, (i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'h5A),
                         i == 5);
        send_request(MODE_GRID, 8'hA5, 1'b0);
        send_request(MODE_GRID, 8'hFF, 1'b0);
        send_request(MODE_PATTERN, 8'hFF, 1'b1);
        chars = '{grid_copy[4], grid_copy[5], grid_copy[6], grid_copy[7]};
        send_pattern(chars);
        chars = '{grid_copy[1], grid_copy[5], grid_copy[9]};
        send_pattern(chars);
        send_random_pattern(5);
        send_random_pattern(40);
        send_request(MODE_PATTERN, 8'h80, 1'b1);

        // Full-size grid, loaded once, with a few searches.
        new_shape(32, 32, 3);
        send_window();
        send_window();
        send_random_pattern(32);
        send_random_pattern(33);

        r = 1;
        for (int phase = 0; sent < TARGET_ITEMS; phase++)
        begin
            case (phase % 8)
                0: new_shape(1, 1, 2);
                1: new_shape(32, 1, 1);
                2: new_shape(1, 32, 0);
                3: new_shape(0, 0, 1);
                4: new_shape(40, 5, 0);
                5: new_shape(2, 63, 1);
                default:
                begin
                    r = $urandom_range(8, 1);
                    c = $urandom_range(8, 1);
                    new_shape(r, c, $urandom_range(3));
                end
            endcase
            random_traffic(12);
            if (phase == 3)
            begin
                wait_idle();
                random_traffic(4);
            end
        end

        wait_idle();
        repeat (100) @(negedge clk);
        $display("Covered %0d requests over %0d grid shapes; %0d searches, %0d hits.",
                 sent, settings_seen, result_count, hit_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/glphs_pkg.sv
hw/rtl/glphs_queue.sv
hw/rtl/glphs_front.sv
hw/rtl/glphs_back.sv
hw/rtl/grid_line_pattern_hash_search.sv
hw/rtl/glphs_checker.sv
tb/glphs_checker.sv
tb/tb.sv
